// ===== sv/fsk4mf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk4mf_pkg
// Types, codes and the character table of the four-level FSK message framer.
// ----------------------------------------------------------------------------
package fsk4mf_pkg;

    localparam int MAX_CHARS_DEF    = 48;
    localparam int CHARSET_SIZE_DEF = 74;
    localparam int CNT_W            = 6;
    localparam int CMDQ_DEPTH       = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [1:0] CFG_MIN_ID = 2'd0;
    localparam logic [1:0] CFG_MAX_ID = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_TERM   = 3'd2;
    localparam logic [2:0] KIND_PAD    = 3'd3;
    localparam logic [2:0] KIND_CSUM   = 3'd4;

    localparam logic [7:0] TERM_INDEX = 8'd66;
    localparam logic [7:0] PAD_INDEX  = 8'd65;
    localparam logic [7:0] NO_INDEX   = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [7:0]  sender_id;
        logic [15:0] dest_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0] digit_3;
        logic [1:0] digit_2;
        logic [1:0] digit_1;
        logic [1:0] digit_0;
        logic [2:0] group_kind;
        logic       is_last;
        logic [7:0] symbol_total;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [7:0]        byte_val;
        logic [15:0]       mask;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    function automatic logic [7:0] char_index(input logic [7:0] c);
        logic [7:0] idx;
        idx = NO_INDEX;
        if (c >= 8'h61 && c <= 8'h7A) begin
            idx = c - 8'h61;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            idx = c - 8'h41 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            idx = c - 8'h30 + 8'd52;
        end else begin
            case (c)
                8'h2E: idx = 8'd62;
                8'h3F: idx = 8'd63;
                8'h21: idx = 8'd64;
                8'h20: idx = 8'd65;
                8'h24: idx = 8'd66;
                8'h28: idx = 8'd67;
                8'h29: idx = 8'd68;
                8'h2B: idx = 8'd69;
                8'h2D: idx = 8'd70;
                8'h2A: idx = 8'd71;
                8'h2F: idx = 8'd72;
                8'h3D: idx = 8'd73;
                8'h0A: idx = 8'd74;
                default: idx = NO_INDEX;
            endcase
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== sv/fsk4mf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk4mf_front
// Holds the configuration, takes input items, checks and maps them and turns
// each kept item into a command for the sequencer.
// ----------------------------------------------------------------------------
module fsk4mf_front #(
    parameter int MAX_CHARS    = fsk4mf_pkg::MAX_CHARS_DEF,
    parameter int CHARSET_SIZE = fsk4mf_pkg::CHARSET_SIZE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_accept,
    input  wire fsk4mf_pkg::t_in_item  i_item,
    output fsk4mf_pkg::t_cmd           o_cmd,
    output logic                       o_cmd_push
);
    import fsk4mf_pkg::*;

    logic [7:0]       r_min_id;
    logic [7:0]       r_max_id;
    logic [15:0]      r_valid_mask;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       w_idx;
    logic [7:0]       w_sid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_id     <= 8'd1;
            r_max_id     <= 8'd15;
            r_valid_mask <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_ID: r_min_id     <= i_cfg_data[7:0];
                CFG_MAX_ID: r_max_id     <= i_cfg_data[7:0];
                CFG_MASK:   r_valid_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_idx = char_index(i_item.char_code);
        if (i_item.sender_id < r_min_id || i_item.sender_id > r_max_id) begin
            w_sid = r_min_id;
        end else begin
            w_sid = i_item.sender_id;
        end
        n_count        = r_count;
        o_cmd_push     = 1'b0;
        o_cmd.op       = CMD_START;
        o_cmd.byte_val = w_sid;
        o_cmd.mask     = i_item.dest_mask & r_valid_mask;
        o_cmd.count    = r_count;
        if (i_accept) begin
            unique case (i_item.opcode)
                OP_START: begin
                    o_cmd_push = 1'b1;
                    n_count    = '0;
                end
                OP_CHAR: begin
                    o_cmd.op       = CMD_CHAR;
                    o_cmd.byte_val = w_idx;
                    if (32'(r_count) < MAX_CHARS && 32'(w_idx) < CHARSET_SIZE) begin
                        o_cmd_push = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
                OP_END: begin
                    o_cmd.op   = CMD_END;
                    o_cmd_push = 1'b1;
                    n_count    = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fsk4mf_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk4mf_cmd_fifo
// Short command queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module fsk4mf_cmd_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire fsk4mf_pkg::t_cmd  i_cmd,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output fsk4mf_pkg::t_cmd       o_cmd
);
    import fsk4mf_pkg::*;

    localparam int PtrW = $clog2(CMDQ_DEPTH);

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_fill;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_fill == (PtrW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/fsk4mf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk4mf_back
// Sequencer that turns commands into symbol groups, keeps the checksum and
// the symbol count and holds the waiting result in an output register.
// ----------------------------------------------------------------------------
module fsk4mf_back #(
    parameter int MAX_CHARS = fsk4mf_pkg::MAX_CHARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire fsk4mf_pkg::t_cmd  i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output fsk4mf_pkg::t_out_item  o_item
);
    import fsk4mf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR1 = 4'b0010,
        S_HDR2 = 4'b0100,
        S_PAD  = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [15:0]      r_mask;
    logic [15:0]      n_mask;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       r_csum;
    logic [7:0]       n_csum;
    logic [7:0]       r_sym;
    logic [7:0]       n_sym;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             w_go;
    logic             w_emit;
    logic [7:0]       w_byte;
    logic [2:0]       w_kind;
    logic             w_last;
    logic             w_clear;
    logic [7:0]       w_sym_next;

    assign w_go       = !r_out_valid || i_pop;
    assign w_sym_next = r_sym + 8'd4;
    assign o_empty    = !r_out_valid;
    assign o_item     = r_out;

    always_comb begin
        n_state   = r_state;
        n_mask    = r_mask;
        n_cnt     = r_cnt;
        o_cmd_pop = 1'b0;
        w_emit    = 1'b0;
        w_byte    = i_cmd.byte_val;
        w_kind    = KIND_HEADER;
        w_last    = 1'b0;
        w_clear   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_go) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_START: begin
                            w_emit  = 1'b1;
                            w_clear = 1'b1;
                            n_mask  = i_cmd.mask;
                            n_state = S_HDR1;
                        end
                        CMD_CHAR: begin
                            w_emit = 1'b1;
                            w_kind = KIND_CHAR;
                        end
                        CMD_END: begin
                            n_state = S_PAD;
                            n_cnt   = i_cmd.count;
                            if (32'(i_cmd.count) < MAX_CHARS) begin
                                w_emit = 1'b1;
                                w_byte = TERM_INDEX;
                                w_kind = KIND_TERM;
                                n_cnt  = i_cmd.count + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR1: begin
                w_byte = r_mask[7:0];
                if (w_go) begin
                    w_emit  = 1'b1;
                    n_state = S_HDR2;
                end
            end
            S_HDR2: begin
                w_byte = r_mask[15:8];
                if (w_go) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (32'(r_cnt) < MAX_CHARS) begin
                    w_byte = PAD_INDEX;
                    w_kind = KIND_PAD;
                    if (w_go) begin
                        w_emit = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end else begin
                    w_byte = r_csum;
                    w_kind = KIND_CSUM;
                    w_last = 1'b1;
                    if (w_go) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_csum = r_csum;
        n_sym  = r_sym;
        if (w_emit) begin
            if (w_clear) begin
                n_csum = w_byte;
                n_sym  = 8'd4;
            end else if (w_kind == KIND_CSUM) begin
                n_csum = '0;
                n_sym  = '0;
            end else begin
                n_csum = r_csum ^ w_byte;
                n_sym  = w_sym_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_csum      <= '0;
            r_sym       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_csum  <= n_csum;
            r_sym   <= n_sym;
            if (w_go) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        if (w_go && w_emit) begin
            r_out.digit_3      <= w_byte[7:6];
            r_out.digit_2      <= w_byte[5:4];
            r_out.digit_1      <= w_byte[3:2];
            r_out.digit_0      <= w_byte[1:0];
            r_out.group_kind   <= w_kind;
            r_out.is_last      <= w_last;
            r_out.symbol_total <= w_clear ? 8'd4 : w_sym_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fsk4_message_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk4_message_framer
// Frames a text message into groups of four base-4 digits for a 4-FSK link.
// ----------------------------------------------------------------------------
// While full is low, items are taken one per cycle into a four-entry command
// queue; unknown characters, characters past the limit and opcode 3 are taken
// and dropped. The sequencer behind it gives one result group per cycle while
// its output is empty or popped: a header and two mask groups per start item,
// one per kept character, a terminator if room remains, pads to MAX_CHARS and
// the checksum per end item. full stays high while the queue holds 4 commands.
module fsk4_message_framer #(
    parameter int MAX_CHARS    = fsk4mf_pkg::MAX_CHARS_DEF,
    parameter int CHARSET_SIZE = fsk4mf_pkg::CHARSET_SIZE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire fsk4mf_pkg::t_in_item  i_in_item,
    output logic                       empty,
    input  wire logic                  pop,
    output fsk4mf_pkg::t_out_item      o_out_item
);
    import fsk4mf_pkg::*;

    t_cmd w_front_cmd;
    logic w_front_push;
    t_cmd w_q_cmd;
    logic w_q_valid;
    logic w_q_pop;

    fsk4mf_front #(
        .MAX_CHARS    (MAX_CHARS),
        .CHARSET_SIZE (CHARSET_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (push && !full),
        .i_item     (i_in_item),
        .o_cmd      (w_front_cmd),
        .o_cmd_push (w_front_push)
    );

    fsk4mf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    fsk4mf_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule
`default_nettype wire
